FILE: hdl/oaht_pkg.sv
// Package: types and constants of the open-address hash table.
`timescale 1ns / 1ps
package oaht_pkg;
	localparam int HASH_BITS = 30;
	localparam int CFG_BITS  = 11;
	localparam int DIV_STEPS = 10;
	localparam int DIV_BITS  = 3;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_FETCH  = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_END       = 3'd4;

	localparam logic [1:0] MARK_FREE    = 2'd0;
	localparam logic [1:0] MARK_USED    = 2'd1;
	localparam logic [1:0] MARK_DELETED = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_DIV,
		S_READ,
		S_EVAL,
		S_DONE
	} state_t;
endpackage

FILE: hdl/oaht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/open_address_hash_table.sv
// Top level: open-address hash table with linear probing.
`timescale 1ns / 1ps
// Usage:
//   Command channel: raise start with operation, hash, key, value and iter_pos;
//   the word is taken at a clock edge where start is high and busy is low.
//   Result channel: done strobes for one cycle with status, key_out,
//   value_out, next_iter and live_count. The receiver cannot stall it.
//   The user must write table_size via table_size_we while idle (unenforced).
// Sequence:
//   Insert, lookup and remove: hash modulo table size (three quotient bits
//   per cycle), then for each probed slot a mark and data RAM read and an
//   evaluate, then the result in S_DONE and a return to idle.
//   Fetch: a read and an evaluate per scanned slot, then S_DONE. Clear: a
//   sweep of all TABLE_DEPTH mark RAM slots, then S_DONE. Other codes: S_DONE.
//   The probe loop through the one-read-port mark and data RAMs sets the rate.
// Reset:
//   After arst_n is released the block sweeps all TABLE_DEPTH mark RAM slots
//   to free, one slot a cycle, with busy high; counters reset to zero.
module open_address_hash_table #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BITS    = 64,
	parameter int VALUE_BITS  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  table_size_we,
	input  logic [10:0]           table_size,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            operation,
	input  logic [31:0]           hash,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [10:0]           iter_pos,
	output logic                  done,
	output logic [2:0]            status,
	output logic [KEY_BITS-1:0]   key_out,
	output logic [VALUE_BITS-1:0] value_out,
	output logic [10:0]           next_iter,
	output logic [10:0]           live_count
);
	import oaht_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int PW = (AW + 1 > CFG_BITS) ? AW + 1 : CFG_BITS;
	localparam int DW = HASH_BITS + KEY_BITS + VALUE_BITS;
	localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	logic [10:0]           ts_q;
	logic [2:0]            op_q;
	logic [HASH_BITS-1:0]  hash_q, hsh_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [PW-1:0]         idx_q, start_q, pos_q, rem_q, rem_nx, n_eff, idx_inc;
	logic                  dir_q, have_q, pfree_q, clr_op_q;
	logic [3:0]            dcnt_q;
	logic [AW-1:0]         sweep_q;
	logic [10:0]           used_q, tomb_q;
	logic [2:0]            status_q;
	logic [KEY_BITS-1:0]   ko_q;
	logic [VALUE_BITS-1:0] vo_q;
	logic [10:0]           nxt_q;

	logic                  accept;
	logic [1:0]            mark_rd, mark_wd;
	logic                  mark_we, data_we;
	logic [AW-1:0]         mark_wa, commit_a;
	logic [DW-1:0]         data_rd;
	logic                  s_free, s_del, s_used, s_hit, exhausted, fin, fetch_far;
	logic                  ins_commit, rem_commit, commit_free;

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		n_eff = PW'(ts_q);
		if (ts_q == 11'd0) begin
			n_eff = PW'(1);
		end else if (PW'(ts_q) > PW'(TABLE_DEPTH)) begin
			n_eff = PW'(TABLE_DEPTH);
		end
	end

	always_comb begin
		logic [PW:0] r;
		r = {1'b0, rem_q};
		for (int b = 0; b < DIV_BITS; b++) begin
			r = {r[PW-1:0], hsh_q[HASH_BITS-1-b]};
			if (r >= {1'b0, n_eff}) begin
				r = r - {1'b0, n_eff};
			end
		end
		rem_nx = r[PW-1:0];
	end

	assign idx_inc   = idx_q + PW'(1);
	assign fetch_far = PW'(iter_pos) >= n_eff;

	assign s_free = mark_rd == MARK_FREE;
	assign s_del  = mark_rd == MARK_DELETED;
	assign s_used = mark_rd == MARK_USED;
	assign s_hit  = s_used && (data_rd[DW-1 -: HASH_BITS] == hash_q)
		&& (data_rd[VALUE_BITS +: KEY_BITS] == key_q);

	always_comb begin
		if (op_q == OP_FETCH) begin
			exhausted = idx_inc == n_eff;
			fin = s_used || exhausted;
		end else begin
			exhausted = (!dir_q && idx_inc == n_eff && start_q == '0)
				|| (dir_q && idx_q == '0);
			fin = s_hit || s_free || exhausted;
		end
	end

	assign ins_commit = (state_q == S_EVAL) && (op_q == OP_INSERT) && !s_hit
		&& (s_free || (exhausted && (have_q || s_del)));
	assign rem_commit = (state_q == S_EVAL) && (op_q == OP_REMOVE) && s_hit;
	assign commit_a    = have_q ? pos_q[AW-1:0] : idx_q[AW-1:0];
	assign commit_free = have_q ? pfree_q : s_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (operation)
						OP_INSERT, OP_LOOKUP, OP_REMOVE: state_d = S_DIV;
						OP_FETCH: state_d = fetch_far ? S_DONE : S_READ;
						OP_CLEAR: state_d = S_CLEAR;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_CLEAR: begin
				if (sweep_q == LAST) begin
					state_d = clr_op_q ? S_DONE : S_IDLE;
				end
			end
			S_DIV: begin
				if (dcnt_q == 4'(DIV_STEPS - 1)) begin
					state_d = S_READ;
				end
			end
			S_READ:  state_d = S_EVAL;
			S_EVAL:  state_d = fin ? S_DONE : S_READ;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy    = state_q != S_IDLE;
		done    = state_q == S_DONE;
		mark_we = (state_q == S_CLEAR) || ins_commit || rem_commit;
		data_we = ins_commit;
		if (state_q == S_CLEAR) begin
			mark_wa = sweep_q;
			mark_wd = MARK_FREE;
		end else if (ins_commit) begin
			mark_wa = commit_a;
			mark_wd = MARK_USED;
		end else begin
			mark_wa = idx_q[AW-1:0];
			mark_wd = MARK_DELETED;
		end
	end

	oaht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_mark (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_wa),
		.wdata (mark_wd),
		.raddr (idx_q[AW-1:0]),
		.rdata (mark_rd)
	);

	oaht_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_data (
		.clk   (clk),
		.we    (data_we),
		.waddr (commit_a),
		.wdata ({hash_q, key_q, val_q}),
		.raddr (idx_q[AW-1:0]),
		.rdata (data_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			ts_q     <= 11'd1021;
			sweep_q  <= '0;
			clr_op_q <= 1'b0;
			used_q   <= '0;
			tomb_q   <= '0;
		end else begin
			state_q <= state_d;
			if (table_size_we) begin
				ts_q <= table_size;
			end
			if (state_q == S_CLEAR) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (accept && operation == OP_CLEAR) begin
				clr_op_q <= 1'b1;
				sweep_q  <= '0;
				used_q   <= '0;
				tomb_q   <= '0;
			end
			if (ins_commit) begin
				if (commit_free) begin
					used_q <= used_q + 11'd1;
				end else begin
					tomb_q <= tomb_q - 11'd1;
				end
			end
			if (rem_commit) begin
				tomb_q <= tomb_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			hash_q   <= hash[HASH_BITS-1:0];
			hsh_q    <= hash[HASH_BITS-1:0];
			key_q    <= key;
			val_q    <= value;
			rem_q    <= '0;
			dcnt_q   <= '0;
			dir_q    <= 1'b0;
			have_q   <= 1'b0;
			pfree_q  <= 1'b0;
			idx_q    <= PW'(iter_pos);
			ko_q     <= '0;
			vo_q     <= '0;
			if (operation == OP_FETCH && fetch_far) begin
				status_q <= ST_END;
				nxt_q    <= n_eff[10:0];
			end else begin
				status_q <= ST_OK;
				nxt_q    <= '0;
			end
		end
		if (state_q == S_DIV) begin
			rem_q  <= rem_nx;
			hsh_q  <= hsh_q << DIV_BITS;
			dcnt_q <= dcnt_q + 4'd1;
			idx_q   <= rem_nx;
			start_q <= rem_nx;
		end
		if (state_q == S_EVAL) begin
			if (op_q == OP_FETCH) begin
				if (s_used) begin
					ko_q  <= data_rd[VALUE_BITS +: KEY_BITS];
					vo_q  <= data_rd[VALUE_BITS-1:0];
					nxt_q <= idx_inc[10:0];
				end else if (exhausted) begin
					status_q <= ST_END;
					nxt_q    <= n_eff[10:0];
				end
				idx_q <= idx_inc;
			end else begin
				if (op_q == OP_INSERT) begin
					if (s_hit) begin
						status_q <= ST_DUP;
					end else if (!s_free && exhausted && !have_q && !s_del) begin
						status_q <= ST_FULL;
					end
					if (!have_q && (s_free || s_del)) begin
						have_q  <= 1'b1;
						pos_q   <= idx_q;
						pfree_q <= s_free;
					end
				end else begin
					if (s_hit) begin
						vo_q <= data_rd[VALUE_BITS-1:0];
					end else if (s_free || exhausted) begin
						status_q <= ST_NOT_FOUND;
					end
				end
				if (dir_q) begin
					idx_q <= idx_q - PW'(1);
				end else if (idx_inc == n_eff) begin
					dir_q <= 1'b1;
					idx_q <= start_q - PW'(1);
				end else begin
					idx_q <= idx_inc;
				end
			end
		end
	end

	assign status     = status_q;
	assign key_out    = ko_q;
	assign value_out  = vo_q;
	assign next_iter  = nxt_q;
	assign live_count = used_q - tomb_q;
endmodule

FILE: dv/tb_top.sv
// Testbench for the open-address hash table: queued driver, clocked monitor, table predictor.
`timescale 1ns / 1ps
module tb_top;
	import oaht_pkg::*;

	localparam int DEPTH = 1024;
	localparam logic [2:0] OP_NONE_FIRST = 3'd5;
	localparam logic [2:0] OP_NONE_LAST  = 3'd7;
	localparam int SETTLE = 2300;

	typedef enum logic [1:0] {W_OP, W_SIZE, W_DRAIN} word_kind_t;

	typedef struct {
		word_kind_t  kind;
		logic [2:0]  op;
		logic [31:0] hsh;
		logic [63:0] k;
		logic [63:0] v;
		logic [10:0] it;
		logic [10:0] size_val;
		int          idle_pct;
	} cmd_word_t;

	typedef struct {
		logic [2:0]  st;
		logic [63:0] k;
		logic [63:0] v;
		logic [10:0] nxt;
		logic [10:0] live;
	} reply_t;

	logic clk, arst_n;
	logic table_size_we;
	logic [10:0] table_size;
	logic start, busy;
	logic [2:0] operation;
	logic [31:0] hash;
	logic [63:0] key, value;
	logic [10:0] iter_pos;
	logic done;
	logic [2:0] status;
	logic [63:0] key_out, value_out;
	logic [10:0] next_iter, live_count;

	open_address_hash_table dut (
		.clk(clk), .arst_n(arst_n),
		.table_size_we(table_size_we), .table_size(table_size),
		.start(start), .busy(busy),
		.operation(operation), .hash(hash), .key(key), .value(value), .iter_pos(iter_pos),
		.done(done), .status(status), .key_out(key_out), .value_out(value_out),
		.next_iter(next_iter), .live_count(live_count)
	);

	cmd_word_t cmd_queue[$];
	reply_t    reply_queue[$];
	int        errors;
	logic      taken;

	// table shadow
	logic [1:0]  sh_mark[DEPTH];
	logic [29:0] sh_hash[DEPTH];
	logic [63:0] sh_key[DEPTH];
	logic [63:0] sh_val[DEPTH];
	logic [10:0] sh_used, sh_tomb, sh_size;

	logic [31:0] pool_h[12];
	logic [63:0] pool_k[12];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#150ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int unsigned probe_span();
		if (sh_size == 0) return 1;
		if (sh_size > DEPTH) return DEPTH;
		return sh_size;
	endfunction

	function automatic bit locate_key(input logic [29:0] h, input logic [63:0] k,
			output int unsigned pos);
		int unsigned n;
		int unsigned s;
		n = probe_span();
		s = h % n;
		pos = 0;
		for (int unsigned i = s; i < n; i++) begin
			if (sh_mark[i] == MARK_FREE) return 0;
			if (sh_mark[i] == MARK_USED && sh_hash[i] == h && sh_key[i] == k) begin
				pos = i;
				return 1;
			end
		end
		for (int j = int'(s) - 1; j >= 0; j--) begin
			if (sh_mark[j] == MARK_FREE) return 0;
			if (sh_mark[j] == MARK_USED && sh_hash[j] == h && sh_key[j] == k) begin
				pos = j;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic logic [2:0] insert_key(input logic [29:0] h, input logic [63:0] k,
			input logic [63:0] v);
		int unsigned n;
		int unsigned s;
		int unsigned pos;
		bit have;
		bit hit_free;
		n = probe_span();
		s = h % n;
		pos = 0;
		have = 0;
		hit_free = 0;
		for (int unsigned i = s; i < n; i++) begin
			if (sh_mark[i] == MARK_FREE) begin
				if (!have) begin
					have = 1;
					pos = i;
				end
				hit_free = 1;
				break;
			end
			if (sh_mark[i] == MARK_DELETED) begin
				if (!have) begin
					have = 1;
					pos = i;
				end
			end else if (sh_hash[i] == h && sh_key[i] == k) begin
				return ST_DUP;
			end
		end
		if (!hit_free) begin
			for (int j = int'(s) - 1; j >= 0; j--) begin
				if (sh_mark[j] == MARK_FREE) begin
					if (!have) begin
						have = 1;
						pos = j;
					end
					break;
				end
				if (sh_mark[j] == MARK_DELETED) begin
					if (!have) begin
						have = 1;
						pos = j;
					end
				end else if (sh_hash[j] == h && sh_key[j] == k) begin
					return ST_DUP;
				end
			end
		end
		if (!have) return ST_FULL;
		if (sh_mark[pos] == MARK_FREE) sh_used++;
		else sh_tomb--;
		sh_mark[pos] = MARK_USED;
		sh_hash[pos] = h;
		sh_key[pos] = k;
		sh_val[pos] = v;
		return ST_OK;
	endfunction

	function automatic reply_t table_predict(input cmd_word_t w);
		reply_t r;
		logic [29:0] h;
		int unsigned n;
		int unsigned pos;
		h = w.hsh[29:0];
		n = probe_span();
		r = '{st: ST_OK, k: '0, v: '0, nxt: '0, live: '0};
		case (w.op)
			OP_INSERT: r.st = insert_key(h, w.k, w.v);
			OP_LOOKUP: begin
				if (locate_key(h, w.k, pos)) r.v = sh_val[pos];
				else r.st = ST_NOT_FOUND;
			end
			OP_REMOVE: begin
				if (locate_key(h, w.k, pos)) begin
					r.v = sh_val[pos];
					sh_mark[pos] = MARK_DELETED;
					sh_tomb++;
				end else begin
					r.st = ST_NOT_FOUND;
				end
			end
			OP_FETCH: begin
				r.st = ST_END;
				r.nxt = 11'(n);
				for (int unsigned i = w.it; i < n; i++) begin
					if (sh_mark[i] == MARK_USED) begin
						r.st = ST_OK;
						r.k = sh_key[i];
						r.v = sh_val[i];
						r.nxt = 11'(i + 1);
						break;
					end
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < DEPTH; i++) sh_mark[i] = MARK_FREE;
				sh_used = '0;
				sh_tomb = '0;
			end
			default: ;
		endcase
		r.live = sh_used - sh_tomb;
		return r;
	endfunction

	task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
		$display("mismatch %s: expected %h got %h at %0t", field, want, got, $realtime);
		errors++;
	endtask

	// driver
	always @(negedge clk) begin
		logic n_start;
		logic n_we;
		cmd_word_t w;
		n_start = 1'b0;
		n_we = 1'b0;
		if (arst_n) begin
			if (start && !taken) begin
				n_start = 1'b1;
			end else if (cmd_queue.size() > 0) begin
				w = cmd_queue[0];
				case (w.kind)
					W_OP: begin
						if ($urandom_range(99) >= w.idle_pct) begin
							void'(cmd_queue.pop_front());
							operation <= w.op;
							hash <= w.hsh;
							key <= w.k;
							value <= w.v;
							iter_pos <= w.it;
							n_start = 1'b1;
						end
					end
					W_SIZE: begin
						if (reply_queue.size() == 0 && !busy && !table_size_we) begin
							void'(cmd_queue.pop_front());
							table_size <= w.size_val;
							n_we = 1'b1;
						end
					end
					default: begin
						if (reply_queue.size() == 0) void'(cmd_queue.pop_front());
					end
				endcase
			end
		end
		start <= n_start;
		table_size_we <= n_we;
	end

	// monitor and predictor
	always @(posedge clk) begin
		reply_t e;
		cmd_word_t w;
		if (arst_n) begin
			taken <= start && !busy;
			if (done) begin
				if (reply_queue.size() == 0) begin
					report("unexpected word", 64'd0, 64'd1);
				end else begin
					e = reply_queue.pop_front();
					if (status !== e.st) report("status", e.st, status);
					if (key_out !== e.k) report("key_out", e.k, key_out);
					if (value_out !== e.v) report("value_out", e.v, value_out);
					if (next_iter !== e.nxt) report("next_iter", e.nxt, next_iter);
					if (live_count !== e.live) report("live_count", e.live, live_count);
				end
			end
			if (table_size_we) sh_size = table_size;
			if (start && !busy) begin
				w = '{kind: W_OP, op: operation, hsh: hash, k: key, v: value, it: iter_pos,
					size_val: '0, idle_pct: 0};
				reply_queue.push_back(table_predict(w));
			end
		end else begin
			taken <= 1'b0;
		end
	end

	task automatic push_op(input logic [2:0] op, input logic [31:0] h, input logic [63:0] k,
			input logic [63:0] v, input logic [10:0] it, input int idle);
		cmd_queue.push_back('{kind: W_OP, op: op, hsh: h, k: k, v: v, it: it,
			size_val: '0, idle_pct: idle});
	endtask

	task automatic push_size(input logic [10:0] sz);
		cmd_queue.push_back('{kind: W_DRAIN, op: OP_INSERT, hsh: '0, k: '0, v: '0, it: '0,
			size_val: '0, idle_pct: 0});
		cmd_queue.push_back('{kind: W_SIZE, op: OP_INSERT, hsh: '0, k: '0, v: '0, it: '0,
			size_val: sz, idle_pct: 0});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_phase(input logic [10:0] sz, input int count, input int idle);
		int pick;
		int slot;
		int pool_n;
		logic [2:0] op;
		logic [31:0] h;
		logic [63:0] k;
		logic [10:0] it;
		push_size(sz);
		pool_n = (sz > 0 && sz < 12) ? sz + 2 : 12;
		for (int i = 0; i < 12; i++) begin
			if ($urandom_range(1)) begin
				pool_h[i] = $urandom;
				pool_k[i] = rand64();
			end
		end
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 35) op = OP_INSERT;
			else if (pick < 55) op = OP_LOOKUP;
			else if (pick < 75) op = OP_REMOVE;
			else if (pick < 94) op = OP_FETCH;
			else if (pick < 97) op = OP_CLEAR;
			else op = 3'($urandom_range(OP_NONE_LAST, OP_NONE_FIRST));
			slot = $urandom_range(pool_n - 1);
			h = pool_h[slot] ^ ({$urandom} << 30);
			k = pool_k[slot];
			if ($urandom_range(9) == 0) begin
				h = $urandom;
				k = rand64();
			end
			if ($urandom_range(9) == 0) it = 11'($urandom);
			else it = 11'($urandom_range((sz == 0 || sz > DEPTH) ? DEPTH : sz));
			push_op(op, h, k, rand64(), it, idle);
		end
	endtask

	initial begin
		errors = 0;
		arst_n = 1'b0;
		start = 1'b0;
		table_size_we = 1'b0;
		table_size = 11'd1021;
		operation = OP_INSERT;
		hash = '0;
		key = '0;
		value = '0;
		iter_pos = '0;
		taken = 1'b0;
		sh_size = 11'd1021;
		sh_used = '0;
		sh_tomb = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sh_mark[i] = MARK_FREE;
			sh_hash[i] = '0;
			sh_key[i] = '0;
			sh_val[i] = '0;
		end
		for (int i = 0; i < 12; i++) begin
			pool_h[i] = $urandom;
			pool_k[i] = rand64();
		end

		push_op(OP_INSERT, 32'h0, 64'h0, 64'hffff_ffff_ffff_ffff, 11'd0, 0);
		push_op(OP_INSERT, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0, 11'd0, 0);
		push_op(OP_INSERT, 32'h3fff_ffff, 64'hffff_ffff_ffff_ffff, 64'h1234, 11'd0, 0);
		push_op(OP_INSERT, 32'h0, 64'h0, 64'h55, 11'd0, 0);
		push_op(OP_LOOKUP, 32'hc000_0000, 64'h0, 64'h0, 11'd0, 0);
		push_op(OP_LOOKUP, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0, 11'd0, 0);
		push_op(OP_FETCH, 32'h0, 64'h0, 64'h0, 11'd0, 0);
		push_op(OP_FETCH, 32'h0, 64'h0, 64'h0, 11'd1, 0);
		push_op(OP_FETCH, 32'h0, 64'h0, 64'h0, 11'd1021, 0);
		push_op(OP_FETCH, 32'h0, 64'h0, 64'h0, 11'd2047, 0);
		push_op(OP_REMOVE, 32'h0, 64'h0, 64'h0, 11'd0, 0);
		push_op(OP_LOOKUP, 32'h0, 64'h0, 64'h0, 11'd0, 0);
		push_op(OP_REMOVE, 32'h0, 64'h0, 64'h0, 11'd0, 0);
		push_op(OP_INSERT, 32'h0, 64'h0, 64'h77, 11'd0, 0);
		push_op(OP_NONE_FIRST, 32'hffff_ffff, 64'h1, 64'h1, 11'd2047, 0);
		push_op(OP_NONE_LAST, 32'h0, 64'h0, 64'h0, 11'd0, 0);
		push_size(11'd3);
		push_op(OP_INSERT, 32'd4, 64'hffff_ffff_ffff_ffff, 64'h1, 11'd0, 0);
		push_op(OP_INSERT, 32'd4, 64'h2, 64'h2, 11'd0, 0);
		push_op(OP_INSERT, 32'd4, 64'h3, 64'h3, 11'd0, 0);
		push_op(OP_REMOVE, 32'd4, 64'h2, 64'h0, 11'd0, 0);
		push_op(OP_INSERT, 32'd2, 64'h5, 64'h5, 11'd0, 0);
		push_op(OP_FETCH, 32'h0, 64'h0, 64'h0, 11'd3, 0);
		push_op(OP_CLEAR, 32'h0, 64'h0, 64'h0, 11'd0, 0);
		push_op(OP_FETCH, 32'h0, 64'h0, 64'h0, 11'd0, 0);

		random_phase(11'd7, 150, 7);
		random_phase(11'd1, 60, 7);
		random_phase(11'd13, 200, 7);
		random_phase(11'd0, 50, 45);
		random_phase(11'd31, 200, 45);
		random_phase(11'd2047, 40, 45);
		random_phase(11'd5, 150, 0);
		random_phase(11'd1021, 200, 0);
		random_phase(11'd1024, 40, 0);
		random_phase(11'd97, 160, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_queue.size() != 0 || start || reply_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

FILE: open_address_hash_table.f
hdl/oaht_pkg.sv
hdl/oaht_ram.sv
hdl/open_address_hash_table.sv
dv/tb_top.sv
